FILE: src/rke_pkg.sv
// ----------------------------------------------------------------------------
// rke_pkg
// Shared types, codes and constants of the RSA key and modexp engine.
// ----------------------------------------------------------------------------
package rke_pkg;

    localparam int WORD_W          = 32;
    localparam int FAC_W           = 16;
    localparam int FACTOR_WIDTH_DEF = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int STATUS_W        = 2;
    localparam int TRIAL_W         = 9;

    localparam int P_RESET = 61;
    localparam int Q_RESET = 53;
    localparam int E_RESET = 17;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [FAC_W-1:0]     fac_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [STATUS_W-1:0]  status_t;
    typedef logic [TRIAL_W-1:0]   trial_t;

    // register indexes of the configuration port
    localparam cfg_idx_t CFG_P = 2'd0;
    localparam cfg_idx_t CFG_Q = 2'd1;
    localparam cfg_idx_t CFG_E = 2'd2;

    // result status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_PRIME = 2'd1;
    localparam status_t ST_NO_INV    = 2'd2;

    typedef enum logic {
        ALU_DIV,
        ALU_MULMOD
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_st_t;

    typedef struct packed {
        logic clear;
    } key_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEYGEN,
        S_PRIME_P,
        S_PRIME_Q,
        S_INV_RED,
        S_INV_LOOP,
        S_INV_MUL,
        S_EXP_START,
        S_EXP_RED,
        S_EXP_STEP,
        S_EXP_MUL,
        S_EXP_SQR,
        S_OUT
    } seq_state_t;

endpackage

FILE: src/rke_cfg_if.sv
// ----------------------------------------------------------------------------
// rke_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rke_cfg_if;
    logic              valid;
    logic              ready;
    rke_pkg::cfg_idx_t index;
    rke_pkg::word_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/rke_req_if.sv
// ----------------------------------------------------------------------------
// rke_req_if
// Request channel: command and value of one transaction.
// ----------------------------------------------------------------------------
interface rke_req_if;
    logic           valid;
    logic           ready;
    logic           command;
    rke_pkg::word_t value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

FILE: src/rke_rsp_if.sv
// ----------------------------------------------------------------------------
// rke_rsp_if
// Response channel: result and status of one transaction.
// ----------------------------------------------------------------------------
interface rke_rsp_if;
    logic             valid;
    logic             ready;
    rke_pkg::word_t   result;
    rke_pkg::status_t status;

    modport source (output valid, output result, output status, input ready);
    modport sink   (input valid, input result, input status, output ready);
endinterface

FILE: src/rke_alu.sv
// ----------------------------------------------------------------------------
// rke_alu
// Shared bit-serial unit: divide (quotient and remainder) or modular
// multiply, one bit of the operand per cycle.
// ----------------------------------------------------------------------------
module rke_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  rke_pkg::alu_ctl_t ctl,
    input  rke_pkg::word_t    a,
    input  rke_pkg::word_t    b,
    input  rke_pkg::word_t    m,
    output rke_pkg::alu_st_t  st,
    output rke_pkg::word_t    quo,
    output rke_pkg::word_t    rem
);

    localparam int STEPS = rke_pkg::WORD_W;
    localparam int CNT_W = $clog2(STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    rke_pkg::alu_op_t  op_reg, op_next;
    rke_pkg::word_t    sh_reg, sh_next;
    rke_pkg::word_t    add_reg, add_next;
    rke_pkg::word_t    den_reg, den_next;
    rke_pkg::word_t    acc_reg, acc_next;
    rke_pkg::word_t    quo_reg, quo_next;

    logic                      top;
    logic [rke_pkg::WORD_W:0]  dbl, s1, s2, s3, den_x;
    logic                      ge1, ge2;

    // one shift-and-reduce step
    always_comb
    begin
        top   = sh_reg[rke_pkg::WORD_W-1];
        den_x = {1'b0, den_reg};
        dbl   = {acc_reg, (op_reg == rke_pkg::ALU_DIV) & top};
        ge1   = (dbl >= den_x);
        s1    = ge1 ? (dbl - den_x) : dbl;
        s2    = {1'b0, s1[rke_pkg::WORD_W-1:0]} + {1'b0, (top ? add_reg : '0)};
        ge2   = (s2 >= den_x);
        s3    = ge2 ? (s2 - den_x) : s2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        sh_next   = sh_reg;
        add_next  = add_reg;
        den_next  = den_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = ctl.op;
            sh_next   = (ctl.op == rke_pkg::ALU_DIV) ? a : b;
            add_next  = a;
            den_next  = m;
            acc_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            sh_next  = {sh_reg[rke_pkg::WORD_W-2:0], 1'b0};
            quo_next = {quo_reg[rke_pkg::WORD_W-2:0], ge1};
            acc_next = (op_reg == rke_pkg::ALU_DIV) ? s1[rke_pkg::WORD_W-1:0]
                                                    : s3[rke_pkg::WORD_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= rke_pkg::ALU_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        add_reg <= add_next;
        den_reg <= den_next;
        acc_reg <= acc_next;
        quo_reg <= quo_next;
    end

    assign st.busy = busy_reg;
    assign st.done = done_reg;
    assign quo     = quo_reg;
    assign rem     = acc_reg;

endmodule

FILE: src/rke_seq.sv
// ----------------------------------------------------------------------------
// rke_seq
// Sequencer: key derivation (trial division, extended Euclid) and
// square-and-multiply exponentiation on the shared unit; holds key state
// and the response register.
// ----------------------------------------------------------------------------
module rke_seq #(
    parameter  int FACTOR_WIDTH = rke_pkg::FACTOR_WIDTH_DEF,
    localparam int FW_EFF = (FACTOR_WIDTH < rke_pkg::FAC_W) ? FACTOR_WIDTH : rke_pkg::FAC_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FW_EFF-1:0] prime_p,
    input  logic [FW_EFF-1:0] prime_q,
    input  rke_pkg::word_t    public_exponent,
    input  rke_pkg::key_ctl_t key_ctl,
    rke_req_if.sink           req,
    rke_rsp_if.source         rsp
);

    localparam int II_W = 2 * rke_pkg::TRIAL_W;

    rke_pkg::seq_state_t state_reg, state_next;
    logic                issued_reg, issued_next;
    logic                key_ready_reg, key_ready_next;
    rke_pkg::status_t    key_status_reg, key_status_next;
    rke_pkg::word_t      modulus_reg, modulus_next;
    rke_pkg::word_t      totient_reg, totient_next;
    rke_pkg::word_t      priv_reg, priv_next;
    logic                cmd_reg, cmd_next;
    rke_pkg::word_t      val_reg, val_next;
    rke_pkg::trial_t     trial_reg, trial_next;
    rke_pkg::word_t      r0_reg, r0_next;
    rke_pkg::word_t      r1_reg, r1_next;
    rke_pkg::word_t      t0_reg, t0_next;
    rke_pkg::word_t      t1_reg, t1_next;
    rke_pkg::word_t      qt_reg, qt_next;
    rke_pkg::word_t      rk_reg, rk_next;
    rke_pkg::word_t      acc_reg, acc_next;
    rke_pkg::word_t      base_reg, base_next;
    rke_pkg::word_t      exp_reg, exp_next;
    logic                out_valid_reg, out_valid_next;
    rke_pkg::word_t      out_result_reg, out_result_next;
    rke_pkg::status_t    out_status_reg, out_status_next;

    rke_pkg::alu_ctl_t alu_ctl;
    rke_pkg::alu_st_t  alu_st;
    rke_pkg::word_t    alu_a, alu_b, alu_m, alu_quo, alu_rem;

    rke_pkg::fac_t     p16, q16, v_cur;
    rke_pkg::word_t    n_calc, phi_calc, qtm, t2;
    logic [II_W-1:0]   ii;
    logic              v_lt2, sq_over, rem_zero, alu_done, out_free;

    rke_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (alu_ctl),
        .a     (alu_a),
        .b     (alu_b),
        .m     (alu_m),
        .st    (alu_st),
        .quo   (alu_quo),
        .rem   (alu_rem)
    );

    always_comb
    begin
        p16      = rke_pkg::fac_t'(prime_p);
        q16      = rke_pkg::fac_t'(prime_q);
        n_calc   = rke_pkg::word_t'(p16) * rke_pkg::word_t'(q16);
        phi_calc = rke_pkg::word_t'(p16 - rke_pkg::fac_t'(p16 != '0))
                 * rke_pkg::word_t'(q16 - rke_pkg::fac_t'(q16 != '0));
        v_cur    = (state_reg == rke_pkg::S_PRIME_P) ? p16 : q16;
        ii       = II_W'(trial_reg) * II_W'(trial_reg);
        v_lt2    = (v_cur < rke_pkg::fac_t'(2));
        sq_over  = (ii > II_W'(v_cur));
        rem_zero = (alu_rem == '0);
        alu_done = issued_reg && alu_st.done;
        out_free = !out_valid_reg || rsp.ready;
        qtm      = (qt_reg == totient_reg) ? '0 : qt_reg;
        // t0 - prod mod totient; both operands already reduced
        t2       = (t0_reg >= alu_rem) ? (t0_reg - alu_rem)
                                       : (t0_reg - alu_rem + totient_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rke_pkg::S_IDLE:
            begin
                if (req.valid)
                    state_next = key_ready_reg ? rke_pkg::S_EXP_START : rke_pkg::S_KEYGEN;
            end
            rke_pkg::S_KEYGEN:
                state_next = rke_pkg::S_PRIME_P;
            rke_pkg::S_PRIME_P, rke_pkg::S_PRIME_Q:
            begin
                if (!issued_reg)
                begin
                    if (v_lt2)
                        state_next = rke_pkg::S_EXP_START;
                    else if (sq_over)
                        state_next = (state_reg == rke_pkg::S_PRIME_P) ? rke_pkg::S_PRIME_Q
                                                                       : rke_pkg::S_INV_RED;
                end
                else if (alu_done && rem_zero)
                    state_next = rke_pkg::S_EXP_START;
            end
            rke_pkg::S_INV_RED:
            begin
                if (alu_done)
                    state_next = rke_pkg::S_INV_LOOP;
            end
            rke_pkg::S_INV_LOOP:
            begin
                if (!issued_reg && r1_reg == '0)
                    state_next = rke_pkg::S_EXP_START;
                else if (alu_done)
                    state_next = rke_pkg::S_INV_MUL;
            end
            rke_pkg::S_INV_MUL:
            begin
                if (alu_done)
                    state_next = rke_pkg::S_INV_LOOP;
            end
            rke_pkg::S_EXP_START:
            begin
                if (key_status_reg != rke_pkg::ST_OK || modulus_reg == '0)
                    state_next = rke_pkg::S_OUT;
                else
                    state_next = rke_pkg::S_EXP_RED;
            end
            rke_pkg::S_EXP_RED:
            begin
                if (alu_done)
                    state_next = rke_pkg::S_EXP_STEP;
            end
            rke_pkg::S_EXP_STEP:
            begin
                if (exp_reg == '0)
                    state_next = rke_pkg::S_OUT;
                else if (exp_reg[0])
                    state_next = rke_pkg::S_EXP_MUL;
                else
                    state_next = rke_pkg::S_EXP_SQR;
            end
            rke_pkg::S_EXP_MUL:
            begin
                if (alu_done)
                    state_next = (exp_reg[rke_pkg::WORD_W-1:1] == '0) ? rke_pkg::S_EXP_STEP
                                                                      : rke_pkg::S_EXP_SQR;
            end
            rke_pkg::S_EXP_SQR:
            begin
                if (alu_done)
                    state_next = rke_pkg::S_EXP_STEP;
            end
            rke_pkg::S_OUT:
            begin
                if (out_free)
                    state_next = rke_pkg::S_IDLE;
            end
            default:
                state_next = rke_pkg::S_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb
    begin
        issued_next     = issued_reg;
        key_ready_next  = key_ready_reg;
        key_status_next = key_status_reg;
        modulus_next    = modulus_reg;
        totient_next    = totient_reg;
        priv_next       = priv_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        trial_next      = trial_reg;
        r0_next         = r0_reg;
        r1_next         = r1_reg;
        t0_next         = t0_reg;
        t1_next         = t1_reg;
        qt_next         = qt_reg;
        rk_next         = rk_reg;
        acc_next        = acc_reg;
        base_next       = base_reg;
        exp_next        = exp_reg;
        out_result_next = out_result_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        alu_ctl.start   = 1'b0;
        alu_ctl.op      = rke_pkg::ALU_DIV;
        alu_a           = '0;
        alu_b           = '0;
        alu_m           = '0;
        if (alu_done)
            issued_next = 1'b0;

        case (state_reg)
            rke_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next = req.command;
                    val_next = req.value;
                end
            end
            rke_pkg::S_KEYGEN:
            begin
                modulus_next    = n_calc;
                totient_next    = phi_calc;
                priv_next       = '0;
                key_status_next = rke_pkg::ST_OK;
                trial_next      = rke_pkg::trial_t'(2);
            end
            rke_pkg::S_PRIME_P, rke_pkg::S_PRIME_Q:
            begin
                alu_a = rke_pkg::word_t'(v_cur);
                alu_m = rke_pkg::word_t'(trial_reg);
                if (!issued_reg)
                begin
                    if (v_lt2)
                    begin
                        key_status_next = rke_pkg::ST_NOT_PRIME;
                        key_ready_next  = 1'b1;
                    end
                    else if (sq_over)
                        trial_next = rke_pkg::trial_t'(2);
                    else
                    begin
                        alu_ctl.start = 1'b1;
                        issued_next   = 1'b1;
                    end
                end
                else if (alu_done)
                begin
                    if (rem_zero)
                    begin
                        key_status_next = rke_pkg::ST_NOT_PRIME;
                        key_ready_next  = 1'b1;
                    end
                    else
                        trial_next = trial_reg + 1'b1;
                end
            end
            rke_pkg::S_INV_RED:
            begin
                alu_a = public_exponent;
                alu_m = totient_reg;
                if (!issued_reg)
                begin
                    alu_ctl.start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (alu_done)
                begin
                    r0_next = totient_reg;
                    r1_next = alu_rem;
                    t0_next = '0;
                    t1_next = rke_pkg::word_t'(totient_reg != rke_pkg::word_t'(1));
                end
            end
            rke_pkg::S_INV_LOOP:
            begin
                alu_a = r0_reg;
                alu_m = r1_reg;
                if (!issued_reg)
                begin
                    if (r1_reg == '0)
                    begin
                        key_ready_next = 1'b1;
                        if (r0_reg == rke_pkg::word_t'(1))
                            priv_next = t0_reg;
                        else
                            key_status_next = rke_pkg::ST_NO_INV;
                    end
                    else
                    begin
                        alu_ctl.start = 1'b1;
                        issued_next   = 1'b1;
                    end
                end
                else if (alu_done)
                begin
                    qt_next = alu_quo;
                    rk_next = alu_rem;
                end
            end
            rke_pkg::S_INV_MUL:
            begin
                alu_ctl.op = rke_pkg::ALU_MULMOD;
                alu_a      = qtm;
                alu_b      = t1_reg;
                alu_m      = totient_reg;
                if (!issued_reg)
                begin
                    alu_ctl.start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (alu_done)
                begin
                    r0_next = r1_reg;
                    r1_next = rk_reg;
                    t0_next = t1_reg;
                    t1_next = t2;
                end
            end
            rke_pkg::S_EXP_START:
            begin
                if (key_status_reg != rke_pkg::ST_OK || modulus_reg == '0)
                    acc_next = '0;
                else
                begin
                    exp_next = cmd_reg ? priv_reg : public_exponent;
                    acc_next = rke_pkg::word_t'(modulus_reg != rke_pkg::word_t'(1));
                end
            end
            rke_pkg::S_EXP_RED:
            begin
                alu_a = val_reg;
                alu_m = modulus_reg;
                if (!issued_reg)
                begin
                    alu_ctl.start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (alu_done)
                    base_next = alu_rem;
            end
            rke_pkg::S_EXP_MUL:
            begin
                alu_ctl.op = rke_pkg::ALU_MULMOD;
                alu_a      = acc_reg;
                alu_b      = base_reg;
                alu_m      = modulus_reg;
                if (!issued_reg)
                begin
                    alu_ctl.start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (alu_done)
                begin
                    acc_next = alu_rem;
                    // last bit: drop the final squaring
                    if (exp_reg[rke_pkg::WORD_W-1:1] == '0)
                        exp_next = '0;
                end
            end
            rke_pkg::S_EXP_SQR:
            begin
                alu_ctl.op = rke_pkg::ALU_MULMOD;
                alu_a      = base_reg;
                alu_b      = base_reg;
                alu_m      = modulus_reg;
                if (!issued_reg)
                begin
                    alu_ctl.start = 1'b1;
                    issued_next   = 1'b1;
                end
                else if (alu_done)
                begin
                    base_next = alu_rem;
                    exp_next  = exp_reg >> 1;
                end
            end
            rke_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = acc_reg;
                    out_status_next = key_status_reg;
                end
            end
            default:
            begin
                issued_next = 1'b0;
            end
        endcase

        if (key_ctl.clear)
            key_ready_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rke_pkg::S_IDLE;
            issued_reg     <= 1'b0;
            key_ready_reg  <= 1'b0;
            key_status_reg <= rke_pkg::ST_OK;
            modulus_reg    <= '0;
            totient_reg    <= '0;
            priv_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issued_reg     <= issued_next;
            key_ready_reg  <= key_ready_next;
            key_status_reg <= key_status_next;
            modulus_reg    <= modulus_next;
            totient_reg    <= totient_next;
            priv_reg       <= priv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        val_reg        <= val_next;
        trial_reg      <= trial_next;
        r0_reg         <= r0_next;
        r1_reg         <= r1_next;
        t0_reg         <= t0_next;
        t1_reg         <= t1_next;
        qt_reg         <= qt_next;
        rk_reg         <= rk_next;
        acc_reg        <= acc_next;
        base_reg       <= base_next;
        exp_reg        <= exp_next;
        out_result_reg <= out_result_next;
        out_status_reg <= out_status_next;
    end

    assign req.ready  = (state_reg == rke_pkg::S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.result = out_result_reg;
    assign rsp.status = out_status_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        alu_ctl.start |-> !alu_st.busy)
        else $error("shared unit started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        alu_st.done |-> $past(alu_st.busy))
        else $error("unit done without a running operation");

    a_bad_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != rke_pkg::ST_OK) |-> rsp.result == '0)
        else $error("nonzero result with a bad key");

    a_bad_key_priv: assert property (@(posedge clk) disable iff (!rst_n)
        (key_ready_reg && key_status_reg != rke_pkg::ST_OK) |-> priv_reg == '0)
        else $error("private exponent set for a bad key");
`endif

endmodule

FILE: src/rsa_key_and_modexp_engine.sv
// Each divide or modular multiply runs on the single shared bit-serial unit.
// Encrypt/decrypt: one reduction of the input, then one modular multiply per set bit
// of the exponent and one squaring per exponent bit below its top bit.
// Key derivation on the first transaction after reset or a register write runs trial
// division (up to 254 per factor), then extended Euclid: a divide and a multiply per step.
// One transaction at a time; reset loads p=61, q=53, e=17, key not derived.
// ----------------------------------------------------------------------------
// rsa_key_and_modexp_engine
// Toy RSA engine: derives the key from configured primes, then performs
// modular exponentiation for encrypt and decrypt transactions.
// ----------------------------------------------------------------------------
module rsa_key_and_modexp_engine #(
    parameter int FACTOR_WIDTH = rke_pkg::FACTOR_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rke_cfg_if.sink   cfg,
    rke_req_if.sink   req,
    rke_rsp_if.source rsp
);

    localparam int FW_EFF = (FACTOR_WIDTH < rke_pkg::FAC_W) ? FACTOR_WIDTH : rke_pkg::FAC_W;

    logic [FW_EFF-1:0] prime_p_reg, prime_p_next;
    logic [FW_EFF-1:0] prime_q_reg, prime_q_next;
    rke_pkg::word_t    exp_e_reg, exp_e_next;
    rke_pkg::key_ctl_t key_ctl;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        prime_p_next  = prime_p_reg;
        prime_q_next  = prime_q_reg;
        exp_e_next    = exp_e_reg;
        key_ctl.clear = cfg.valid && (cfg.index inside {rke_pkg::CFG_P, rke_pkg::CFG_Q,
                                                        rke_pkg::CFG_E});
        if (cfg.valid)
        begin
            case (cfg.index)
                rke_pkg::CFG_P: prime_p_next = cfg.data[FW_EFF-1:0];
                rke_pkg::CFG_Q: prime_q_next = cfg.data[FW_EFF-1:0];
                rke_pkg::CFG_E: exp_e_next   = cfg.data;
                default:        exp_e_next   = exp_e_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_p_reg <= FW_EFF'(rke_pkg::P_RESET);
            prime_q_reg <= FW_EFF'(rke_pkg::Q_RESET);
            exp_e_reg   <= rke_pkg::WORD_W'(rke_pkg::E_RESET);
        end
        else
        begin
            prime_p_reg <= prime_p_next;
            prime_q_reg <= prime_q_next;
            exp_e_reg   <= exp_e_next;
        end
    end

    rke_seq #(
        .FACTOR_WIDTH (FACTOR_WIDTH)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .prime_p         (prime_p_reg),
        .prime_q         (prime_q_reg),
        .public_exponent (exp_e_reg),
        .key_ctl         (key_ctl),
        .req             (req),
        .rsp             (rsp)
    );

endmodule
